>>> rtl/dwsa_pkg.sv
// ----------------------------------------------------------------------------
// Debug watchpoint slot allocator package
// Shared types, operation and status codes, control word layout and helpers.
// ----------------------------------------------------------------------------
package dwsa_pkg;

    // Fixed field widths of the command and result ports
    localparam int ADDR_W   = 64;
    localparam int SERIAL_W = 32;
    localparam int CW_W     = 32;
    localparam int BITS_W   = 7;
    localparam int SLOT_W   = 2;
    localparam int HIT_W    = 4;

    // Hardware limit on slots and parameter defaults
    localparam int MAX_SLOTS           = 4;
    localparam int SLOT_COUNT_DEFAULT  = 4;
    localparam int ADDR_BITS_DEFAULT   = 64;
    localparam int SERIAL_BITS_DEFAULT = 32;

    // Debug control word layout
    localparam logic [CW_W-1:0] CTRL_FIXED = CW_W'((1 << 8) | (1 << 9));
    localparam int CTRL_EN_BASE   = 1;
    localparam int CTRL_MODE_BASE = 16;
    localparam int CTRL_LEN_BASE  = 18;

    // Mode field codes
    localparam logic [1:0] MODE_WRITE_ONLY = 2'd3;
    localparam logic [1:0] MODE_READ_WRITE = 2'd1;

    // Length field codes
    localparam logic [1:0] LEN_8  = 2'd0;
    localparam logic [1:0] LEN_16 = 2'd1;
    localparam logic [1:0] LEN_64 = 2'd2;
    localparam logic [1:0] LEN_32 = 2'd3;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAN  = 2'd2,
        KIND_QUERY  = 2'd3
    } dwsa_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_NOHIT    = 2'd3
    } dwsa_status_t;

    // One registered command beat
    typedef struct packed {
        dwsa_kind_t           kind;
        logic [ADDR_W-1:0]    addr;
        logic [1:0]           len_code;
        logic                 write_only;
        logic [SLOT_W-1:0]    target_slot;
        logic [SERIAL_W-1:0]  target_serial;
        logic [HIT_W-1:0]     hit_bits;
    } dwsa_op_t;

    // Scalar part of one result beat
    typedef struct packed {
        dwsa_status_t         status;
        logic [SLOT_W-1:0]    slot;
        logic [SERIAL_W-1:0]  serial;
        logic [CW_W-1:0]      control_word;
    } dwsa_res_t;

    // Map a watched width in bits to its length code
    function automatic logic [1:0] length_code(input logic [BITS_W-1:0] bits);
        logic [1:0] code;
        case (bits)
            BITS_W'(8):  code = LEN_8;
            BITS_W'(16): code = LEN_16;
            BITS_W'(32): code = LEN_32;
            default:     code = LEN_64;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/debug_watchpoint_slot_allocator.sv
// ----------------------------------------------------------------------------
// Debug watchpoint slot allocator
// Four-slot hardware watchpoint manager: add, remove, clean and hit query.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high; busy never rises, so one
// command can be issued every clock. Each command produces exactly one result
// beat, shown for a single cycle with done high, after the command has passed
// the input register, then the slot engine and result register. The
// receiver cannot stall, so it must capture every done beat. Results show the
// slot table after the command: control_word and addr0..addr3 reflect it, and
// the addresses of unused slots read as zero. Serials come from a wrapping
// counter; the first add after reset gets serial 1.
// ----------------------------------------------------------------------------
module debug_watchpoint_slot_allocator
#(
    parameter int SLOT_COUNT  = dwsa_pkg::SLOT_COUNT_DEFAULT,
    parameter int ADDR_BITS   = dwsa_pkg::ADDR_BITS_DEFAULT,
    parameter int SERIAL_BITS = dwsa_pkg::SERIAL_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [dwsa_pkg::ADDR_W-1:0]     access_addr,
    input  logic [dwsa_pkg::BITS_W-1:0]     access_bits,
    input  logic                            watch_writes,
    input  logic [dwsa_pkg::SLOT_W-1:0]     target_slot,
    input  logic [dwsa_pkg::SERIAL_W-1:0]   target_serial,
    input  logic [dwsa_pkg::HIT_W-1:0]      hit_bits,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [dwsa_pkg::SLOT_W-1:0]     slot,
    output logic [dwsa_pkg::SERIAL_W-1:0]   serial,
    output logic [dwsa_pkg::CW_W-1:0]       control_word,
    output logic [dwsa_pkg::ADDR_W-1:0]     addr0,
    output logic [dwsa_pkg::ADDR_W-1:0]     addr1,
    output logic [dwsa_pkg::ADDR_W-1:0]     addr2,
    output logic [dwsa_pkg::ADDR_W-1:0]     addr3
);

    logic                                                   accept;
    logic                                                   op_valid;
    dwsa_pkg::dwsa_op_t                                     op;
    dwsa_pkg::dwsa_res_t                                    res;
    logic [dwsa_pkg::MAX_SLOTS-1:0][dwsa_pkg::ADDR_W-1:0]   res_addr;

    // Take a command every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    dwsa_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (kind),
        .access_addr   (access_addr),
        .access_bits   (access_bits),
        .watch_writes  (watch_writes),
        .target_slot   (target_slot),
        .target_serial (target_serial),
        .hit_bits      (hit_bits),
        .op_valid      (op_valid),
        .op            (op)
    );

    dwsa_engine
    #(
        .SLOT_COUNT  (SLOT_COUNT),
        .ADDR_BITS   (ADDR_BITS),
        .SERIAL_BITS (SERIAL_BITS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .res_valid (done),
        .res       (res),
        .res_addr  (res_addr)
    );

    // Break out the result beat
    assign status       = res.status;
    assign slot         = res.slot;
    assign serial       = res.serial;
    assign control_word = res.control_word;
    assign addr0        = res_addr[0];
    assign addr1        = res_addr[1];
    assign addr2        = res_addr[2];
    assign addr3        = res_addr[3];

`ifndef SYNTHESIS
    // Every taken command yields a later result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result beat missing after accepted command");

    // A failed add reports no slot and no serial
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dwsa_pkg::ST_FULL) |-> (slot == '0 && serial == '0))
        else $error("full status with nonzero slot or serial");

    // A disabled slot 0 shows a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !control_word[dwsa_pkg::CTRL_EN_BASE]) |-> (addr0 == '0))
        else $error("slot 0 address nonzero while disabled");
`endif

endmodule

>>> rtl/dwsa_in_reg.sv
// ----------------------------------------------------------------------------
// Command input register
// Captures an accepted command beat and pre-decodes the access width.
// ----------------------------------------------------------------------------
module dwsa_in_reg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      kind,
    input  logic [dwsa_pkg::ADDR_W-1:0]     access_addr,
    input  logic [dwsa_pkg::BITS_W-1:0]     access_bits,
    input  logic                            watch_writes,
    input  logic [dwsa_pkg::SLOT_W-1:0]     target_slot,
    input  logic [dwsa_pkg::SERIAL_W-1:0]   target_serial,
    input  logic [dwsa_pkg::HIT_W-1:0]      hit_bits,
    output logic                            op_valid,
    output dwsa_pkg::dwsa_op_t              op
);

    logic               op_valid_reg;
    dwsa_pkg::dwsa_op_t op_reg;
    dwsa_pkg::dwsa_op_t op_next;

    // Pack the beat, decoding the width into its length code
    always_comb
    begin
        op_next.kind          = dwsa_pkg::dwsa_kind_t'(kind);
        op_next.addr          = access_addr;
        op_next.len_code      = dwsa_pkg::length_code(access_bits);
        op_next.write_only    = watch_writes;
        op_next.target_slot   = target_slot;
        op_next.target_serial = target_serial;
        op_next.hit_bits      = hit_bits;
    end

    // Mark a held beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= accept;
        end
    end

    // Hold the payload of an accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

>>> rtl/dwsa_engine.sv
// ----------------------------------------------------------------------------
// Watchpoint slot engine
// Holds the slot table and serial counter, executes one command per cycle
// and registers the result beat with the composed control word.
// ----------------------------------------------------------------------------
module dwsa_engine
#(
    parameter int SLOT_COUNT  = dwsa_pkg::SLOT_COUNT_DEFAULT,
    parameter int ADDR_BITS   = dwsa_pkg::ADDR_BITS_DEFAULT,
    parameter int SERIAL_BITS = dwsa_pkg::SERIAL_BITS_DEFAULT
)
(
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                op_valid,
    input  dwsa_pkg::dwsa_op_t                                  op,
    output logic                                                res_valid,
    output dwsa_pkg::dwsa_res_t                                 res,
    output logic [dwsa_pkg::MAX_SLOTS-1:0][dwsa_pkg::ADDR_W-1:0] res_addr
);

    localparam int SLOT_W = dwsa_pkg::SLOT_W;

    // Slot table
    logic [SLOT_COUNT-1:0]                      used_reg;
    logic [SLOT_COUNT-1:0]                      used_next;
    logic [SLOT_COUNT-1:0][ADDR_BITS-1:0]       addr_reg;
    logic [SLOT_COUNT-1:0][1:0]                 len_reg;
    logic [SLOT_COUNT-1:0]                      wo_reg;
    logic [SLOT_COUNT-1:0][SERIAL_BITS-1:0]     serial_reg;
    logic [SERIAL_BITS-1:0]                     cnt_reg;
    logic [SERIAL_BITS-1:0]                     cnt_next;
    logic [SERIAL_BITS-1:0]                     cnt_inc;

    // Result register
    logic                                                   res_valid_reg;
    dwsa_pkg::dwsa_res_t                                    res_reg;
    dwsa_pkg::dwsa_res_t                                    res_next;
    logic [dwsa_pkg::MAX_SLOTS-1:0][dwsa_pkg::ADDR_W-1:0]   res_addr_reg;
    logic [dwsa_pkg::MAX_SLOTS-1:0][dwsa_pkg::ADDR_W-1:0]   res_addr_next;

    // Search and select
    logic                       free_found;
    logic [SLOT_W-1:0]          free_idx;
    logic [SLOT_COUNT-1:0]      free_sel;
    logic [SLOT_COUNT-1:0]      alloc_sel;
    logic                       hit_found;
    logic [SLOT_W-1:0]          hit_idx;
    logic                       tgt_present;
    logic [SLOT_COUNT-1:0]      tgt_sel;
    logic [SERIAL_BITS-1:0]     tgt_serial;
    logic [SERIAL_BITS-1:0]     op_serial;
    logic                       ser_match;

    assign cnt_inc   = cnt_reg + SERIAL_BITS'(1);
    assign op_serial = op.target_serial[SERIAL_BITS-1:0];
    assign ser_match = tgt_present && ((op_serial == '0) || (op_serial == tgt_serial));

    // Find the lowest free slot, the lowest hit and the named slot
    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        free_sel    = '0;
        hit_found   = 1'b0;
        hit_idx     = '0;
        tgt_present = 1'b0;
        tgt_sel     = '0;
        tgt_serial  = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!free_found && !used_reg[i])
            begin
                free_found  = 1'b1;
                free_idx    = SLOT_W'(i);
                free_sel[i] = 1'b1;
            end
            if (!hit_found && op.hit_bits[i])
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
            if (op.target_slot == SLOT_W'(i))
            begin
                tgt_present = 1'b1;
                tgt_sel[i]  = 1'b1;
                tgt_serial  = serial_reg[i];
            end
        end
    end

    // Execute the held command
    always_comb
    begin
        used_next             = used_reg;
        cnt_next              = cnt_reg;
        alloc_sel             = '0;
        res_next.status       = dwsa_pkg::ST_OK;
        res_next.slot         = '0;
        res_next.serial       = '0;
        if (op_valid)
        begin
            case (op.kind)
                dwsa_pkg::KIND_ADD:
                begin
                    if (free_found)
                    begin
                        alloc_sel       = free_sel;
                        used_next       = used_reg | free_sel;
                        cnt_next        = cnt_inc;
                        res_next.slot   = free_idx;
                        res_next.serial = dwsa_pkg::SERIAL_W'(cnt_inc);
                    end
                    else
                    begin
                        res_next.status = dwsa_pkg::ST_FULL;
                    end
                end
                dwsa_pkg::KIND_REMOVE:
                begin
                    if (ser_match)
                    begin
                        used_next = used_reg & ~tgt_sel;
                    end
                    else
                    begin
                        res_next.status = dwsa_pkg::ST_MISMATCH;
                    end
                end
                dwsa_pkg::KIND_CLEAN:
                begin
                    used_next = '0;
                end
                dwsa_pkg::KIND_QUERY:
                begin
                    if (hit_found)
                    begin
                        res_next.slot = hit_idx;
                    end
                    else
                    begin
                        res_next.status = dwsa_pkg::ST_NOHIT;
                    end
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end

        // Compose the control word and addresses from the updated table
        res_next.control_word = dwsa_pkg::CTRL_FIXED;
        res_addr_next         = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (used_next[i])
            begin
                res_next.control_word[dwsa_pkg::CTRL_EN_BASE + 2 * i] = 1'b1;
                res_next.control_word[dwsa_pkg::CTRL_MODE_BASE + 4 * i +: 2] =
                    (alloc_sel[i] ? op.write_only : wo_reg[i]) ?
                    dwsa_pkg::MODE_WRITE_ONLY : dwsa_pkg::MODE_READ_WRITE;
                res_next.control_word[dwsa_pkg::CTRL_LEN_BASE + 4 * i +: 2] =
                    alloc_sel[i] ? op.len_code : len_reg[i];
                res_addr_next[i] = dwsa_pkg::ADDR_W'(alloc_sel[i] ?
                    op.addr[ADDR_BITS-1:0] : addr_reg[i]);
            end
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= op_valid;
        end
    end

    // Write the allocated slot's payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (alloc_sel[i])
            begin
                addr_reg[i]   <= op.addr[ADDR_BITS-1:0];
                len_reg[i]    <= op.len_code;
                wo_reg[i]     <= op.write_only;
                serial_reg[i] <= cnt_inc;
            end
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            res_reg      <= res_next;
            res_addr_reg <= res_addr_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_addr  = res_addr_reg;

endmodule

>>> bench/watchpoint_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchpoint slot allocator result checker
// Watches the command and result beats of the slot allocator, predicts each
// result from its own copy of the slot table and compares field by field.
// ----------------------------------------------------------------------------
module watchpoint_result_checker
    import dwsa_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEFAULT,
    parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
    parameter int SERIAL_BITS = SERIAL_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [ADDR_W-1:0]           access_addr,
    input  logic [BITS_W-1:0]           access_bits,
    input  logic                        watch_writes,
    input  logic [SLOT_W-1:0]           target_slot,
    input  logic [SERIAL_W-1:0]         target_serial,
    input  logic [HIT_W-1:0]            hit_bits,
    input  logic                        done,
    input  logic [1:0]                  status,
    input  logic [SLOT_W-1:0]           slot,
    input  logic [SERIAL_W-1:0]         serial,
    input  logic [CW_W-1:0]             control_word,
    input  logic [ADDR_W-1:0]           addr0,
    input  logic [ADDR_W-1:0]           addr1,
    input  logic [ADDR_W-1:0]           addr2,
    input  logic [ADDR_W-1:0]           addr3,
    output int                          fail_count,
    output int                          pending,
    output logic [MAX_SLOTS-1:0]        slots_written,
    output logic [MAX_SLOTS-1:0][SERIAL_W-1:0] slot_serials
);

    localparam logic [ADDR_W-1:0]   ADDR_MASK   = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
    localparam logic [SERIAL_W-1:0] SERIAL_MASK = {SERIAL_W{1'b1}} >> (SERIAL_W - SERIAL_BITS);

    typedef struct packed {
        dwsa_status_t                       status;
        logic [SLOT_W-1:0]                  slot;
        logic [SERIAL_W-1:0]                serial;
        logic [CW_W-1:0]                    control_word;
        logic [MAX_SLOTS-1:0][ADDR_W-1:0]   addrs;
    } slot_answer_t;

    // Predicted slot table
    logic [MAX_SLOTS-1:0]                   in_use;
    logic [MAX_SLOTS-1:0]                   written;
    logic [MAX_SLOTS-1:0][ADDR_W-1:0]       watch_addr;
    logic [MAX_SLOTS-1:0][1:0]              len_code;
    logic [MAX_SLOTS-1:0]                   write_only;
    logic [MAX_SLOTS-1:0][SERIAL_W-1:0]     stored_serial;
    logic [SERIAL_W-1:0]                    serial_counter;

    slot_answer_t expected_answers[$];

    initial fail_count = 0;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        fail_count++;
    endtask

    // Apply one accepted command to the slot table and queue its answer
    task automatic predict_slot_command();
        slot_answer_t ans;
        int           free_idx;
        int           i;
        logic [SERIAL_W-1:0] match_serial;
        ans = '0;
        ans.status = ST_OK;
        free_idx = -1;
        case (dwsa_kind_t'(kind))
            KIND_ADD:
            begin
                for (i = 0; i < SLOT_COUNT; i++)
                    if (!in_use[i] && free_idx < 0)
                        free_idx = i;
                if (free_idx >= 0)
                begin
                    serial_counter = (serial_counter + 1'b1) & SERIAL_MASK;
                    in_use[free_idx]        = 1'b1;
                    written[free_idx]       = 1'b1;
                    watch_addr[free_idx]    = access_addr & ADDR_MASK;
                    write_only[free_idx]    = watch_writes;
                    stored_serial[free_idx] = serial_counter;
                    case (access_bits)
                        BITS_W'(8):  len_code[free_idx] = LEN_8;
                        BITS_W'(16): len_code[free_idx] = LEN_16;
                        BITS_W'(32): len_code[free_idx] = LEN_32;
                        default:     len_code[free_idx] = LEN_64;
                    endcase
                    ans.slot   = SLOT_W'(free_idx);
                    ans.serial = serial_counter;
                end
                else
                begin
                    ans.status = ST_FULL;
                end
            end
            KIND_REMOVE:
            begin
                match_serial = target_serial & SERIAL_MASK;
                if (int'(target_slot) < SLOT_COUNT &&
                    (match_serial == '0 || match_serial == stored_serial[target_slot]))
                    in_use[target_slot] = 1'b0;
                else
                    ans.status = ST_MISMATCH;
            end
            KIND_CLEAN:
            begin
                in_use = '0;
            end
            default:
            begin
                ans.status = ST_NOHIT;
                for (i = SLOT_COUNT - 1; i >= 0; i--)
                begin
                    if (hit_bits[i])
                    begin
                        ans.status = ST_OK;
                        ans.slot   = SLOT_W'(i);
                    end
                end
            end
        endcase

        // Compose the control word and address view from the updated table
        ans.control_word = CTRL_FIXED;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            if (in_use[i])
            begin
                ans.control_word[CTRL_EN_BASE + 2*i] = 1'b1;
                ans.control_word[CTRL_MODE_BASE + 4*i +: 2] =
                    write_only[i] ? MODE_WRITE_ONLY : MODE_READ_WRITE;
                ans.control_word[CTRL_LEN_BASE + 4*i +: 2] = len_code[i];
                ans.addrs[i] = watch_addr[i];
            end
        end
        expected_answers.push_back(ans);
    endtask

    // Compare one result beat with the oldest expected answer
    task automatic check_result_beat();
        slot_answer_t want;
        if (expected_answers.size() == 0)
        begin
            $display("%0t: result beat with no command outstanding", $time);
            fail_count++;
        end
        else
        begin
            want = expected_answers.pop_front();
            if (status != want.status)
                report_mismatch("status", 64'(status), 64'(want.status));
            if (slot != want.slot)
                report_mismatch("slot", 64'(slot), 64'(want.slot));
            if (serial != want.serial)
                report_mismatch("serial", 64'(serial), 64'(want.serial));
            if (control_word != want.control_word)
                report_mismatch("control_word", 64'(control_word), 64'(want.control_word));
            if (addr0 != want.addrs[0])
                report_mismatch("addr0", addr0, want.addrs[0]);
            if (addr1 != want.addrs[1])
                report_mismatch("addr1", addr1, want.addrs[1]);
            if (addr2 != want.addrs[2])
                report_mismatch("addr2", addr2, want.addrs[2]);
            if (addr3 != want.addrs[3])
                report_mismatch("addr3", addr3, want.addrs[3]);
        end
    endtask

    // Check results before predicting, then publish the table to the stimulus side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_use         = '0;
            written        = '0;
            watch_addr     = '0;
            len_code       = '0;
            write_only     = '0;
            stored_serial  = '0;
            serial_counter = '0;
            expected_answers.delete();
        end
        else
        begin
            if (done)
                check_result_beat();
            if (start && !busy)
                predict_slot_command();
        end
        slots_written <= written;
        slot_serials  <= stored_serial;
        pending       <= expected_answers.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchpoint slot allocator testbench
// Drives directed and random add, remove, clean and query commands in bursts
// and hands every beat to the result checker, which gives the failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import dwsa_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        dwsa_kind_t             kind;
        logic [ADDR_W-1:0]      addr;
        logic [BITS_W-1:0]      bits;
        logic                   writes_only;
        logic [SLOT_W-1:0]      tslot;
        logic [SERIAL_W-1:0]    tserial;
        logic [HIT_W-1:0]       hits;
    } watch_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             kind = '0;
    logic [ADDR_W-1:0]      access_addr = '0;
    logic [BITS_W-1:0]      access_bits = '0;
    logic                   watch_writes = 1'b0;
    logic [SLOT_W-1:0]      target_slot = '0;
    logic [SERIAL_W-1:0]    target_serial = '0;
    logic [HIT_W-1:0]       hit_bits = '0;
    logic                   done;
    logic [1:0]             status;
    logic [SLOT_W-1:0]      slot;
    logic [SERIAL_W-1:0]    serial;
    logic [CW_W-1:0]        control_word;
    logic [ADDR_W-1:0]      addr0;
    logic [ADDR_W-1:0]      addr1;
    logic [ADDR_W-1:0]      addr2;
    logic [ADDR_W-1:0]      addr3;

    int                     fail_count;
    int                     pending;
    logic [MAX_SLOTS-1:0]   slots_written;
    logic [MAX_SLOTS-1:0][SERIAL_W-1:0] slot_serials;
    int                     idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    debug_watchpoint_slot_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .access_addr(access_addr), .access_bits(access_bits),
        .watch_writes(watch_writes), .target_slot(target_slot),
        .target_serial(target_serial), .hit_bits(hit_bits), .done(done),
        .status(status), .slot(slot), .serial(serial),
        .control_word(control_word), .addr0(addr0), .addr1(addr1),
        .addr2(addr2), .addr3(addr3)
    );

    watchpoint_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .access_addr(access_addr), .access_bits(access_bits),
        .watch_writes(watch_writes), .target_slot(target_slot),
        .target_serial(target_serial), .hit_bits(hit_bits), .done(done),
        .status(status), .slot(slot), .serial(serial),
        .control_word(control_word), .addr0(addr0), .addr1(addr1),
        .addr2(addr2), .addr3(addr3), .fail_count(fail_count),
        .pending(pending), .slots_written(slots_written),
        .slot_serials(slot_serials)
    );

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic watch_cmd_t make_cmd(input dwsa_kind_t k, input logic [ADDR_W-1:0] a,
                                            input int bits, input int wr,
                                            input int ts, input logic [SERIAL_W-1:0] ser,
                                            input logic [HIT_W-1:0] hits);
        watch_cmd_t c;
        c.kind        = k;
        c.addr        = a;
        c.bits        = BITS_W'(bits);
        c.writes_only = 1'(wr);
        c.tslot       = SLOT_W'(ts);
        c.tserial     = ser;
        c.hits        = hits;
        return c;
    endfunction

    // Hold one command beat until the block takes it
    task automatic send_command(input watch_cmd_t c);
        start         <= 1'b1;
        kind          <= c.kind;
        access_addr   <= c.addr;
        access_bits   <= c.bits;
        watch_writes  <= c.writes_only;
        target_slot   <= c.tslot;
        target_serial <= c.tserial;
        hit_bits      <= c.hits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random command with well-formed removes most of the time
    task automatic make_random_cmd(output watch_cmd_t c);
        int pick;
        c.addr        = {$urandom, $urandom};
        c.bits        = BITS_W'($urandom_range(0, 64));
        c.writes_only = 1'($urandom_range(0, 1));
        c.tslot       = SLOT_W'($urandom_range(0, 3));
        c.tserial     = $urandom;
        c.hits        = HIT_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 19);
        if (pick < 8)
            c.kind = KIND_ADD;
        else if (pick < 14)
            c.kind = KIND_REMOVE;
        else if (pick < 18)
            c.kind = KIND_QUERY;
        else
            c.kind = KIND_CLEAN;

        // Favor the width codes and the address extremes
        pick = $urandom_range(0, 9);
        if (pick < 4)
            c.bits = BITS_W'(8 << pick);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.addr = '0;
        else if (pick == 1)
            c.addr = '1;

        // Never compare against a serial that was never stored
        if (c.kind == KIND_REMOVE)
        begin
            pick = $urandom_range(0, 9);
            if (!slots_written[c.tslot] || pick < 2)
                c.tserial = '0;
            else if (pick < 6)
                c.tserial = slot_serials[c.tslot];
            else if (pick == 6)
                c.tserial = slot_serials[c.tslot] + 1'b1;
        end
    endtask

    initial
    begin
        watch_cmd_t cmd;
        watch_cmd_t directed[$];
        int         burst_left;
        int         gap;
        int         n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, fill to full, each width code, removes, clean
        directed.push_back(make_cmd(KIND_QUERY,  '0, 0, 0, 0, '0, 4'h0));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 0, '0, 4'h0));
        directed.push_back(make_cmd(KIND_ADD, '0, 8, 0, 3, '1, 4'hf));
        directed.push_back(make_cmd(KIND_ADD, '1, 16, 1, 0, '0, 4'h0));
        directed.push_back(make_cmd(KIND_ADD, {16{4'h5}}, 32, 0, 1, 32'h5, 4'h3));
        directed.push_back(make_cmd(KIND_ADD, {16{4'ha}}, 64, 1, 2, 32'ha, 4'hc));
        directed.push_back(make_cmd(KIND_ADD, 64'h1234, 0, 1, 0, 32'h0, 4'h0));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'hf));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'h8));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'h4));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'h2));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 1, 32'd99, 4'h0));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 1, 32'd2, 4'h0));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 1, 32'd2, 4'h0));
        directed.push_back(make_cmd(KIND_ADD, 64'h8000_0000_0000_0001, 7, 0, 0, '0, 4'h0));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 3, '0, 4'h0));
        directed.push_back(make_cmd(KIND_REMOVE, '0, 0, 0, 2, '1, 4'h0));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'h8));
        directed.push_back(make_cmd(KIND_CLEAN, '1, 127, 1, 3, '1, 4'hf));
        directed.push_back(make_cmd(KIND_QUERY, '0, 0, 0, 0, '0, 4'h0));
        directed.push_back(make_cmd(KIND_ADD, '1, 63, 1, 3, '1, 4'hf));
        foreach (directed[i])
            send_command(directed[i]);

        // Let the table settle before the random part
        drain_results();

        // Random bursts with random gaps, now and then a full drain
        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            make_random_cmd(cmd);
            send_command(cmd);
            if ($urandom_range(0, 149) == 0)
                drain_results();
            else if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20)
                                                   : $urandom_range(1, 3);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(0, 30);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
